>>> rtl/mptd_pkg.sv
// Package with types, constants and helpers for the task dispatcher.
package mptd_pkg;

  localparam int MaxTasksDef  = 16;
  localparam int TimeWidthDef = 21;
  localparam int SlotW        = 4;
  localparam int DurW         = 16;
  localparam int PrioW        = 8;
  localparam int OutTimeW     = 21;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 16;

  localparam logic [CfgIdxW-1:0] REG_POLICY  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_QUANTUM = 1'd1;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    POL_FCFS  = 3'd0,
    POL_SJF   = 3'd1,
    POL_SRTF  = 3'd2,
    POL_PRIO  = 3'd3,
    POL_RR    = 3'd4
  } policy_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RR_ADMIT,
    ST_RR_DROP,
    ST_RUN,
    ST_FINISH,
    ST_RR_ADMIT2,
    ST_RR_PUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [DurW-1:0]  arrival;
    logic [DurW-1:0]  burst;
    logic [PrioW-1:0] prio_level;
  } in_word_t;

  typedef struct packed {
    logic [SlotW-1:0]    slot;
    logic [DurW-1:0]     run_length;
    logic [OutTimeW-1:0] end_time;
    logic                finished;
    logic [OutTimeW-1:0] wait_time;
    logic [OutTimeW-1:0] turnaround;
    logic                idle_step;
    logic                merged;
    logic                all_done;
    logic                error;
  } out_word_t;

  // Scan control between sequencer and compare unit.
  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

endpackage

>>> rtl/multi_policy_task_dispatcher_unit.sv
// Top level of the multi-policy task dispatcher with its sequencer and tables.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_word  (in_word_t)
// out     | output    | out_valid/ out_ready | out_word (out_word_t)
// cfg     | input     | cfg_we               | cfg_idx, cfg_data
//
// A load, clear or status word passes through the done state before its result shows.
// A dispatch scans every slot with one comparator, one slot a cycle, then decides and, if a
// task is picked, runs and finishes it before the done state. Round robin admits arrived
// tasks to the ring and drops finished entries from the head; when a task runs, it admits
// again and pushes an unfinished task back to the ring before the done state. The input is not
// ready while a word is at work or a result waits.
// Reset empties the table, sets time to zero and clears the ring pointers.
module multi_policy_task_dispatcher_unit import mptd_pkg::*; #(
  parameter int MAX_TASKS  = MaxTasksDef,
  parameter int TIME_WIDTH = TimeWidthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_word,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};

  logic [2:0]      policy_mode;
  logic [DurW-1:0] time_quantum;

  logic [DurW-1:0]  arr_t [MAX_TASKS];
  logic [DurW-1:0]  bur_t [MAX_TASKS];
  logic [PrioW-1:0] pri_t [MAX_TASKS];
  logic [DurW-1:0]  rem_t [MAX_TASKS];
  logic [IW-1:0]    ring  [MAX_TASKS];

  logic [CW-1:0]         entry_count, done_count, next_admit, ring_fill;
  logic [IW-1:0]         ring_head;
  logic [CW-1:0]         last_slot;
  logic [TIME_WIDTH-1:0] now_time;

  state_t    state, state_next;
  out_word_t res;
  logic [CW-1:0] scan_idx;
  logic [IW-1:0] sel;
  logic [DurW-1:0] run_len;
  scan_ctl_t sctl;
  logic      found;
  logic [IW-1:0] best;
  logic      elig;
  logic [DurW-1:0] key;
  logic [2:0] pm;

  assign pm = (policy_mode > POL_RR) ? POL_FCFS : policy_mode;
  assign in_ready = (state == ST_IDLE) && !out_valid;

  // Per-slot eligibility and key for the shared compare unit.
  always_comb begin
    logic [IW-1:0] i;
    i = scan_idx[IW-1:0];
    elig = (scan_idx < entry_count) && (rem_t[i] != '0);
    if (pm != POL_FCFS) begin
      elig = elig && ({{(TIME_WIDTH-DurW){1'b0}}, arr_t[i]} <= now_time);
    end
    case (pm)
      POL_SJF:  key = bur_t[i];
      POL_SRTF: key = rem_t[i];
      POL_PRIO: key = {{(DurW-PrioW){1'b0}}, pri_t[i]};
      default:  key = arr_t[i];
    endcase
  end

  assign sctl.start = (state == ST_IDLE);
  assign sctl.step  = (state == ST_SCAN);

  mptd_scan #(.MAX_TASKS(MAX_TASKS)) u_scan (
    .clk(clk), .rst(rst), .ctl(sctl), .idx(scan_idx[IW-1:0]), .elig(elig),
    .key(key), .found(found), .best(best)
  );

  logic [IW-1:0] ring_tail;
  logic [IW-1:0] head_slot;
  logic [IW-1:0] adm;
  logic          can_admit;
  assign ring_tail = ring_head + ring_fill[IW-1:0];
  assign head_slot = ring[ring_head];
  assign adm       = next_admit[IW-1:0];
  assign can_admit = (next_admit < entry_count) &&
                     ({{(TIME_WIDTH-DurW){1'b0}}, arr_t[adm]} <= now_time);

  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] new_time, tat, wt;
  assign sum      = {1'b0, now_time} + {{(TIME_WIDTH+1-DurW){1'b0}}, run_len};
  assign new_time = sum[TIME_WIDTH] ? TMAX : sum[TIME_WIDTH-1:0];
  always_comb begin
    logic [TIME_WIDTH-1:0] a, b;
    a = {{(TIME_WIDTH-DurW){1'b0}}, arr_t[sel]};
    b = {{(TIME_WIDTH-DurW){1'b0}}, bur_t[sel]};
    tat = (now_time >= a) ? now_time - a : '0;
    wt  = (tat >= b) ? tat - b : '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_word.opcode == OP_DISPATCH && entry_count != '0 &&
              done_count < entry_count) begin
            state_next = (pm == POL_RR) ? ST_RR_ADMIT : ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN:     if (scan_idx == CW'(MAX_TASKS - 1)) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (found && !(pm == POL_FCFS &&
                       {{(TIME_WIDTH-DurW){1'b0}}, arr_t[best]} > now_time)) begin
          state_next = ST_RUN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RR_ADMIT: if (!can_admit) state_next = ST_RR_DROP;
      ST_RR_DROP: begin
        if (ring_fill == '0) state_next = ST_DONE;
        else if (rem_t[head_slot] != '0) state_next = ST_RUN;
      end
      ST_RUN:       state_next = ST_FINISH;
      ST_FINISH:    state_next = (pm == POL_RR) ? ST_RR_ADMIT2 : ST_DONE;
      ST_RR_ADMIT2: if (!can_admit) state_next = ST_RR_PUSH;
      ST_RR_PUSH:   state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode  <= POL_FCFS;
      time_quantum <= 16'd4;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_POLICY:  policy_mode  <= cfg_data[2:0];
        REG_QUANTUM: time_quantum <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done_count  <= '0;
      next_admit  <= '0;
      ring_fill   <= '0;
      ring_head   <= '0;
      last_slot   <= CW'(MAX_TASKS);
      now_time    <= '0;
      out_valid   <= 1'b0;
      scan_idx    <= '0;
      res         <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
        res       <= '0;
      end
      case (state)
        ST_IDLE: begin
          scan_idx <= '0;
          if (in_valid && in_ready) begin
            if (in_word.opcode == OP_LOAD) begin
              if (entry_count >= CW'(MAX_TASKS)) begin
                res.error <= 1'b1;
              end else begin
                arr_t[entry_count[IW-1:0]] <= in_word.arrival;
                bur_t[entry_count[IW-1:0]] <=
                  (in_word.burst == '0) ? DurW'(1) : in_word.burst;
                rem_t[entry_count[IW-1:0]] <=
                  (in_word.burst == '0) ? DurW'(1) : in_word.burst;
                pri_t[entry_count[IW-1:0]] <= in_word.prio_level;
                res.slot <= SlotW'(entry_count);
                entry_count <= entry_count + 1'b1;
              end
            end else if (in_word.opcode == OP_DISPATCH) begin
              if (entry_count == '0) res.error <= 1'b1;
            end else if (in_word.opcode == OP_CLEAR) begin
              entry_count <= '0;
              done_count  <= '0;
              next_admit  <= '0;
              ring_fill   <= '0;
              ring_head   <= '0;
              last_slot   <= CW'(MAX_TASKS);
              now_time    <= '0;
            end
          end
        end
        ST_SCAN: scan_idx <= scan_idx + 1'b1;
        ST_DECIDE: begin
          if (!found) begin
            if (pm != POL_FCFS) begin
              res.idle_step <= 1'b1;
              now_time <= (now_time == TMAX) ? TMAX : now_time + 1'b1;
            end
          end else if (pm == POL_FCFS &&
                       {{(TIME_WIDTH-DurW){1'b0}}, arr_t[best]} > now_time) begin
            res.idle_step <= 1'b1;
            now_time <= {{(TIME_WIDTH-DurW){1'b0}}, arr_t[best]};
          end else begin
            sel     <= best;
            run_len <= (pm == POL_SRTF) ? DurW'(1) : rem_t[best];
          end
        end
        ST_RR_ADMIT: begin
          if (can_admit) begin
            if (rem_t[adm] != '0 && ring_fill < CW'(MAX_TASKS)) begin
              ring[ring_tail] <= adm;
              ring_fill <= ring_fill + 1'b1;
            end
            next_admit <= next_admit + 1'b1;
          end
        end
        ST_RR_DROP: begin
          if (ring_fill == '0) begin
            res.idle_step <= 1'b1;
            if (next_admit < entry_count)
              now_time <= {{(TIME_WIDTH-DurW){1'b0}}, arr_t[adm]};
          end else begin
            ring_head <= ring_head + 1'b1;
            ring_fill <= ring_fill - 1'b1;
            if (rem_t[head_slot] != '0) begin
              sel <= head_slot;
              run_len <= (rem_t[head_slot] <
                          ((time_quantum == '0) ? DurW'(1) : time_quantum)) ?
                         rem_t[head_slot] :
                         ((time_quantum == '0) ? DurW'(1) : time_quantum);
            end
          end
        end
        ST_RUN: begin
          res.slot       <= SlotW'(sel);
          res.run_length <= run_len;
          res.merged     <= (CW'(sel) == last_slot) ? 1'b1 : 1'b0;
          last_slot      <= CW'(sel);
          rem_t[sel]     <= rem_t[sel] - run_len;
          now_time       <= new_time;
        end
        ST_FINISH: begin
          if (rem_t[sel] == '0) begin
            done_count     <= done_count + 1'b1;
            res.finished   <= 1'b1;
            res.wait_time  <= OutTimeW'(wt);
            res.turnaround <= OutTimeW'(tat);
          end
        end
        ST_RR_ADMIT2: begin
          if (can_admit) begin
            if (rem_t[adm] != '0 && ring_fill < CW'(MAX_TASKS)) begin
              ring[ring_tail] <= adm;
              ring_fill <= ring_fill + 1'b1;
            end
            next_admit <= next_admit + 1'b1;
          end
        end
        ST_RR_PUSH: begin
          if (rem_t[sel] != '0 && ring_fill < CW'(MAX_TASKS)) begin
            ring[ring_tail] <= sel;
            ring_fill <= ring_fill + 1'b1;
          end
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          res.end_time <= OutTimeW'(now_time);
          res.all_done <= (entry_count != '0) && (done_count == entry_count);
        end
        default: ;
      endcase
    end
  end

  assign out_word = res;

  // The ring never holds more words than the table has slots.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= CW'(MAX_TASKS)) else $error("ring overfill");
  // Completed tasks never outnumber loaded tasks.
  a_done: assert property (@(posedge clk) disable iff (rst)
    done_count <= entry_count) else $error("done count too high");
  // No new word is taken while a result waits.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accepted over pending result");
  // Time only moves backward through a clear.
  a_time: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> (now_time >= $past(now_time)))
    else $error("time went backward");

endmodule

>>> rtl/mptd_scan.sv
// Shared compare unit that keeps the best candidate over a slot scan.
module mptd_scan import mptd_pkg::*; #(
  parameter int MAX_TASKS  = MaxTasksDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  scan_ctl_t                    ctl,
  input  logic [$clog2(MAX_TASKS)-1:0] idx,
  input  logic                         elig,
  input  logic [DurW-1:0]              key,
  output logic                         found,
  output logic [$clog2(MAX_TASKS)-1:0] best
);

  logic [DurW-1:0] best_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (ctl.step && elig && (!found || key < best_key)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && elig && (!found || key < best_key)) begin
      best_key <= key;
      best     <= idx;
    end
  end

endmodule
